/* sv/touch_point_calibrated_mapping_assert.svh */
// assertion macros for the touch point mapping block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef TOUCH_POINT_CALIBRATED_MAPPING_ASSERT_SVH
`define TOUCH_POINT_CALIBRATED_MAPPING_ASSERT_SVH

`ifndef ASSERT_OFF

// cond holds in a cycle, prop holds in the same cycle
`define TPCM_ASSERT_HOLDS(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("touch mapping check failed");

// cond holds in a cycle, prop holds in the next one
`define TPCM_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("touch mapping check failed");

`else

`define TPCM_ASSERT_HOLDS(label, clk, rst, cond, prop)
`define TPCM_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

/* sv/tpcm_pkg.sv */
// shared types and constants of the touch point mapping block
// no dependencies
package tpcm_pkg;

  localparam int RAW_W         = 12;
  localparam int SUM_W         = RAW_W + 2;
  localparam int PRESS_W       = RAW_W + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 13;
  localparam int PERCENT_SCALE = 100;

  typedef logic [RAW_W-1:0] raw_t;

  // fixed mapping limits when no calibration is loaded
  localparam raw_t FB_X_MIN = 12'd200;
  localparam raw_t FB_X_MAX = 12'd3900;
  localparam raw_t FB_Y_MIN = 12'd300;
  localparam raw_t FB_Y_MAX = 12'd3800;

  localparam logic [PRESS_W-1:0] PRESS_THR_RESET = 13'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_VALID          = 3'd0,
    REG_CAL_A_RAW_X        = 3'd1,
    REG_CAL_A_RAW_Y        = 3'd2,
    REG_CAL_B_RAW_X        = 3'd3,
    REG_CAL_B_RAW_Y        = 3'd4,
    REG_PRESSURE_THRESHOLD = 3'd5,
    REG_IGNORE_PEN_LINE    = 3'd6
  } cfg_reg_t;

  // sideband that travels with each word through the divider
  typedef struct packed {
    logic neg;     // quotient is negative
    logic centre;  // calibration readings equal on this axis
    logic cal;     // two point calibration in use
  } side_t;

endpackage

/* sv/tpcm_front.sv */
// first stage: pen and pressure check, four sample averages per axis
// depends on tpcm_pkg
module tpcm_front (
  input  logic                             clk,
  input  logic                             en,
  input  logic                             load,
  input  logic                             pen_down_n,
  input  tpcm_pkg::raw_t                   pressure_z1,
  input  tpcm_pkg::raw_t                   pressure_z2,
  input  tpcm_pkg::raw_t                   sample_x0,
  input  tpcm_pkg::raw_t                   sample_x1,
  input  tpcm_pkg::raw_t                   sample_x2,
  input  tpcm_pkg::raw_t                   sample_x3,
  input  tpcm_pkg::raw_t                   sample_y0,
  input  tpcm_pkg::raw_t                   sample_y1,
  input  tpcm_pkg::raw_t                   sample_y2,
  input  tpcm_pkg::raw_t                   sample_y3,
  input  logic                             ignore_pen_line,
  input  logic [tpcm_pkg::PRESS_W-1:0]     pressure_threshold,
  output tpcm_pkg::raw_t                   raw_x,
  output tpcm_pkg::raw_t                   raw_y,
  output logic                             press
);
  import tpcm_pkg::*;

  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [PRESS_W-1:0] z_sum;

  assign sum_x = SUM_W'(sample_x0) + SUM_W'(sample_x1) + SUM_W'(sample_x2) + SUM_W'(sample_x3);
  assign sum_y = SUM_W'(sample_y0) + SUM_W'(sample_y1) + SUM_W'(sample_y2) + SUM_W'(sample_y3);
  // z1 + 4095 - z2, where 4095 - z2 is the inverse of z2
  assign z_sum = {1'b0, pressure_z1} + {1'b0, ~pressure_z2};

  always_ff @(posedge clk) begin
    if (en) begin
      raw_x <= sum_x[SUM_W-1:2];
      raw_y <= sum_y[SUM_W-1:2];
      press <= load & (ignore_pen_line | ~pen_down_n) & (z_sum >= pressure_threshold);
    end
  end

endmodule

/* sv/tpcm_div.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on tpcm_pkg
module tpcm_div #(
  parameter int MAG_W = 21
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MAG_W-1:0]      dividend,
  input  tpcm_pkg::raw_t        divisor,
  input  tpcm_pkg::side_t       side_in,
  output logic [MAG_W-1:0]      quotient,
  output tpcm_pkg::side_t       side_out
);
  import tpcm_pkg::*;

  raw_t             rem_r  [MAG_W];
  logic [MAG_W-1:0] sh_r   [MAG_W];
  raw_t             den_r  [MAG_W];
  side_t            side_r [MAG_W];

  raw_t             rem_p  [MAG_W];
  logic [MAG_W-1:0] sh_p   [MAG_W];
  raw_t             den_p  [MAG_W];
  side_t            side_p [MAG_W];
  logic [RAW_W:0]   trial  [MAG_W];
  logic [RAW_W:0]   diff   [MAG_W];
  logic             fits   [MAG_W];

  // sh holds dividend bits still to come at the top and quotient bits at the bottom
  always_comb begin
    for (int k = 0; k < MAG_W; k++) begin
      if (k == 0) begin
        rem_p[k]  = '0;
        sh_p[k]   = dividend;
        den_p[k]  = divisor;
        side_p[k] = side_in;
      end else begin
        rem_p[k]  = rem_r[k-1];
        sh_p[k]   = sh_r[k-1];
        den_p[k]  = den_r[k-1];
        side_p[k] = side_r[k-1];
      end
      trial[k] = {rem_p[k], sh_p[k][MAG_W-1]};
      diff[k]  = trial[k] - {1'b0, den_p[k]};
      fits[k]  = trial[k] >= {1'b0, den_p[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MAG_W; k++) begin
        rem_r[k]  <= fits[k] ? diff[k][RAW_W-1:0] : trial[k][RAW_W-1:0];
        sh_r[k]   <= {sh_p[k][MAG_W-2:0], fits[k]};
        den_r[k]  <= den_p[k];
        side_r[k] <= side_p[k];
      end
    end
  end

  assign quotient = sh_r[MAG_W-1];
  assign side_out = side_r[MAG_W-1];

endmodule

/* sv/tpcm_lane.sv */
// one axis: offset and scale setup, multiply, divide, sign, offset and clamp
// depends on tpcm_pkg and tpcm_div
module tpcm_lane #(
  parameter int             SIZE        = 320,
  parameter int             CAL_PERCENT = 20,
  parameter tpcm_pkg::raw_t FB_MIN      = 12'd300,
  parameter tpcm_pkg::raw_t FB_MAX      = 12'd3800,
  parameter int             MAG_W       = 21,
  parameter int             OUT_W       = 9
) (
  input  logic              clk,
  input  logic              en,
  input  tpcm_pkg::raw_t    raw,
  input  logic              cal_valid,
  input  tpcm_pkg::raw_t    cal_a,
  input  tpcm_pkg::raw_t    cal_b,
  output logic [OUT_W-1:0]  result
);
  import tpcm_pkg::*;

  localparam int PA     = SIZE * CAL_PERCENT / PERCENT_SCALE;
  localparam int PB     = SIZE * (PERCENT_SCALE - CAL_PERCENT) / PERCENT_SCALE;
  localparam int GAIN_W = $clog2(SIZE + 1);
  localparam int PROD_W = RAW_W + GAIN_W;
  localparam int QW     = MAG_W + 1;
  localparam int VW     = MAG_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_CAL = GAIN_W'(PB - PA);
  localparam logic [GAIN_W-1:0] GAIN_FB  = GAIN_W'(SIZE);
  localparam raw_t              DEN_FB   = FB_MAX - FB_MIN;
  localparam logic [QW-1:0]     PA_V     = QW'(PA);
  localparam logic [VW-1:0]     SIZE_V   = VW'(SIZE);
  localparam logic [OUT_W-1:0]  CENTRE_V = OUT_W'(SIZE / 2);
  localparam logic [OUT_W-1:0]  LAST_V   = OUT_W'(SIZE - 1);

  // setup stage
  raw_t                 ref_raw;
  logic signed [RAW_W:0] diff;
  logic signed [RAW_W:0] dcal;
  raw_t                 s2_adiff;
  raw_t                 s2_aden;
  side_t                s2_side;

  always_comb begin
    ref_raw = cal_valid ? cal_a : FB_MIN;
    diff    = $signed({1'b0, raw}) - $signed({1'b0, ref_raw});
    dcal    = $signed({1'b0, cal_b}) - $signed({1'b0, cal_a});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_adiff <= diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
      if (cal_valid) begin
        s2_aden <= dcal[RAW_W] ? RAW_W'(-dcal) : dcal[RAW_W-1:0];
      end else begin
        s2_aden <= DEN_FB;
      end
      s2_side.neg    <= diff[RAW_W] ^ (cal_valid & dcal[RAW_W]);
      s2_side.centre <= cal_valid & (cal_a == cal_b);
      s2_side.cal    <= cal_valid;
    end
  end

  // multiply stage
  logic [GAIN_W-1:0] gain;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  s3_mag;
  raw_t              s3_aden;
  side_t             s3_side;

  assign gain = s2_side.cal ? GAIN_CAL : GAIN_FB;
  assign prod = s2_adiff * gain;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag  <= MAG_W'(prod);
      s3_aden <= s2_aden;
      s3_side <= s2_side;
    end
  end

  // magnitude division
  logic [MAG_W-1:0] quo;
  side_t            d_side;

  tpcm_div #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk      (clk),
    .en       (en),
    .dividend (s3_mag),
    .divisor  (s3_aden),
    .side_in  (s3_side),
    .quotient (quo),
    .side_out (d_side)
  );

  // sign stage
  logic signed [QW-1:0] f1_q;
  side_t                f1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_q    <= d_side.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      f1_side <= d_side;
    end
  end

  // offset and clamp stage
  logic [QW-1:0]        off;
  logic signed [VW-1:0] val;

  always_comb begin
    off = f1_side.cal ? PA_V : {QW{1'b0}};
    val = $signed({1'b0, off}) + f1_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f1_side.centre) begin
        result <= CENTRE_V;
      end else if (val[VW-1]) begin
        result <= '0;
      end else if (val >= SIZE_V) begin
        result <= LAST_V;
      end else begin
        result <= val[OUT_W-1:0];
      end
    end
  end

endmodule

/* sv/touch_point_calibrated_mapping.sv */
// MAG_W + 5 register stages from input to result, 26 with the default 320x240 screen
// (MAG_W = 12 + bits of the larger screen side); takes one word per cycle, except
// while a finished point waits; depth is set by the divider, one quotient bit per stage
// reset (synchronous, active high) empties the pipeline and restores register defaults:
// calibration off, calibration points 0, pressure threshold 300, pen line checked
// depends on tpcm_pkg, tpcm_front, tpcm_lane and the assertion macro header
`include "touch_point_calibrated_mapping_assert.svh"

module touch_point_calibrated_mapping #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int CAL_PERCENT   = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpcm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // measurement channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              pen_down_n,
  input  tpcm_pkg::raw_t                    pressure_z1,
  input  tpcm_pkg::raw_t                    pressure_z2,
  input  tpcm_pkg::raw_t                    sample_x0,
  input  tpcm_pkg::raw_t                    sample_x1,
  input  tpcm_pkg::raw_t                    sample_x2,
  input  tpcm_pkg::raw_t                    sample_x3,
  input  tpcm_pkg::raw_t                    sample_y0,
  input  tpcm_pkg::raw_t                    sample_y1,
  input  tpcm_pkg::raw_t                    sample_y2,
  input  tpcm_pkg::raw_t                    sample_y3,
  // point channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              pressed,
  output logic [8:0]                        screen_x,
  output logic [7:0]                        screen_y
);
  import tpcm_pkg::*;

  localparam int MAX_SIDE = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SIZE_W   = $clog2(MAX_SIDE + 1);
  localparam int MAG_W    = RAW_W + SIZE_W;   // widest |diff| * gain product
  localparam int LAT      = MAG_W + 5;        // front, setup, multiply, divider, sign, clamp
  localparam int X_W      = $clog2(SCREEN_WIDTH);
  localparam int Y_W      = $clog2(SCREEN_HEIGHT);

  // configuration registers
  logic               cal_valid;
  raw_t               cal_a_raw_x;
  raw_t               cal_a_raw_y;
  raw_t               cal_b_raw_x;
  raw_t               cal_b_raw_y;
  logic [PRESS_W-1:0] pressure_threshold;
  logic               ignore_pen_line;

  // no register write is taken while reset is held
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_valid          <= 1'b0;
      cal_a_raw_x        <= '0;
      cal_a_raw_y        <= '0;
      cal_b_raw_x        <= '0;
      cal_b_raw_y        <= '0;
      pressure_threshold <= PRESS_THR_RESET;
      ignore_pen_line    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAL_VALID:          cal_valid          <= cfg_data[0];
        REG_CAL_A_RAW_X:        cal_a_raw_x        <= cfg_data[RAW_W-1:0];
        REG_CAL_A_RAW_Y:        cal_a_raw_y        <= cfg_data[RAW_W-1:0];
        REG_CAL_B_RAW_X:        cal_b_raw_x        <= cfg_data[RAW_W-1:0];
        REG_CAL_B_RAW_Y:        cal_b_raw_y        <= cfg_data[RAW_W-1:0];
        REG_PRESSURE_THRESHOLD: pressure_threshold <= cfg_data;
        REG_IGNORE_PEN_LINE:    ignore_pen_line    <= cfg_data[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // whole pipeline moves together; it only holds while a finished point waits
  logic en;
  logic load;

  assign en       = ~out_valid | out_ready;
  // no measurement word is taken while reset is held
  assign in_ready = en & ~rst;
  assign load     = in_valid & in_ready;

  // valid bits and the press flag travel alongside the data stages
  logic [LAT-1:0] vld;
  logic [LAT-1:1] prs;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], load};
    end
  end

  // front stage
  raw_t raw_x;
  raw_t raw_y;
  logic front_press;

  tpcm_front u_front (
    .clk                (clk),
    .en                 (en),
    .load               (load),
    .pen_down_n         (pen_down_n),
    .pressure_z1        (pressure_z1),
    .pressure_z2        (pressure_z2),
    .sample_x0          (sample_x0),
    .sample_x1          (sample_x1),
    .sample_x2          (sample_x2),
    .sample_x3          (sample_x3),
    .sample_y0          (sample_y0),
    .sample_y1          (sample_y1),
    .sample_y2          (sample_y2),
    .sample_y3          (sample_y3),
    .ignore_pen_line    (ignore_pen_line),
    .pressure_threshold (pressure_threshold),
    .raw_x              (raw_x),
    .raw_y              (raw_y),
    .press              (front_press)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      prs <= {prs[LAT-2:1], front_press};
    end
  end

  // axes are swapped: raw y drives screen x, raw x drives screen y
  logic [X_W-1:0] lane_x;
  logic [Y_W-1:0] lane_y;

  tpcm_lane #(
    .SIZE        (SCREEN_WIDTH),
    .CAL_PERCENT (CAL_PERCENT),
    .FB_MIN      (FB_Y_MIN),
    .FB_MAX      (FB_Y_MAX),
    .MAG_W       (MAG_W),
    .OUT_W       (X_W)
  ) u_lane_x (
    .clk       (clk),
    .en        (en),
    .raw       (raw_y),
    .cal_valid (cal_valid),
    .cal_a     (cal_a_raw_y),
    .cal_b     (cal_b_raw_y),
    .result    (lane_x)
  );

  tpcm_lane #(
    .SIZE        (SCREEN_HEIGHT),
    .CAL_PERCENT (CAL_PERCENT),
    .FB_MIN      (FB_X_MIN),
    .FB_MAX      (FB_X_MAX),
    .MAG_W       (MAG_W),
    .OUT_W       (Y_W)
  ) u_lane_y (
    .clk       (clk),
    .en        (en),
    .raw       (raw_x),
    .cal_valid (cal_valid),
    .cal_a     (cal_a_raw_x),
    .cal_b     (cal_b_raw_x),
    .result    (lane_y)
  );

  // last stage of the lanes is the output register; a release reads as the origin
  assign out_valid = vld[LAT-1];
  assign pressed   = prs[LAT-1];
  assign screen_x  = pressed ? 9'(lane_x) : 9'd0;
  assign screen_y  = pressed ? 8'(lane_y) : 8'd0;

  // clamp keeps both lanes on the screen
  `TPCM_ASSERT_HOLDS(a_point_on_screen, clk, rst, out_valid,
    (lane_x <= X_W'(SCREEN_WIDTH - 1)) && (lane_y <= Y_W'(SCREEN_HEIGHT - 1)))
  // a waiting point must hold the input side
  `TPCM_ASSERT_HOLDS(a_stall_holds_input, clk, rst, out_valid && !out_ready, !in_ready)
  // threshold register takes the written word
  `TPCM_ASSERT_NEXT(a_threshold_write, clk, rst,
    cfg_valid && cfg_ready && (cfg_index == REG_PRESSURE_THRESHOLD),
    pressure_threshold == $past(cfg_data))

endmodule

/* bench/tb_top.sv */
// self-checking bench for touch_point_calibrated_mapping: table of directed words, then random
// words over several register settings, each point checked against a typed point or a bench model
// depends on tpcm_pkg and the block itself
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpcm_pkg::*;

  // screen geometry and fixed mapping limits, as the block is built by default
  localparam int SCR_W     = 320;
  localparam int SCR_H     = 240;
  localparam int CAL_PCT   = 20;
  localparam int ADC_TOP   = 4095;
  localparam int FALL_X_LO = 200;
  localparam int FALL_X_HI = 3900;
  localparam int FALL_Y_LO = 300;
  localparam int FALL_Y_HI = 3800;

  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int WORDS_PER_PHASE = 230;
  localparam int PHASES          = 6;
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off
  localparam int FLOOD_WORDS     = 150;  // back-to-back words offered during the hold-off
  localparam int SETTLE_CYCLES   = 40;   // pipeline depth is 26 at this screen size

  // one measurement word, field order matches the port order
  typedef struct packed {
    logic pen_up;
    raw_t z1, z2;
    raw_t x0, x1, x2, x3;
    raw_t y0, y1, y2, y3;
  } meas_t;

  typedef struct packed {
    logic       pressed;
    logic [8:0] sx;
    logic [7:0] sy;
  } point_t;

  typedef enum {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    meas_t                 m;
    bit                    typed;  // expected point written into the table by hand
    point_t                want;
  } row_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_THIRD} rx_mode_t;

  // clock, reset and every block input start at a known value
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  pen_down_n = 1'b1;
  raw_t                  pressure_z1 = '0;
  raw_t                  pressure_z2 = '0;
  raw_t                  sample_x0 = '0;
  raw_t                  sample_x1 = '0;
  raw_t                  sample_x2 = '0;
  raw_t                  sample_x3 = '0;
  raw_t                  sample_y0 = '0;
  raw_t                  sample_y1 = '0;
  raw_t                  sample_y2 = '0;
  raw_t                  sample_y3 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  pressed;
  logic [8:0]            screen_x;
  logic [7:0]            screen_y;

  // bench copy of the register file, held at the reset values until written
  logic               cal_on      = 1'b0;
  raw_t               cal_ax      = '0;
  raw_t               cal_ay      = '0;
  raw_t               cal_bx      = '0;
  raw_t               cal_by      = '0;
  logic [PRESS_W-1:0] press_min   = PRESS_THR_RESET;
  logic               pen_ignored = 1'b0;

  point_t point_q[$];  // points owed by the block, oldest first
  row_t   plan[$];     // directed table

  int errors       = 0;
  int words_sent   = 0;
  int points_seen  = 0;
  int presses_seen = 0;
  int reg_writes   = 0;
  int burst_left   = 0;
  int hold_ticket  = 0;  // bumped by the sender to ask for one long hold-off

  touch_point_calibrated_mapping dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: timeout at %0t ns with %0d points outstanding", $time, point_q.size());
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- mapping model

  function automatic longint clip(longint v, longint lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  // straight line through (ra, pa) and (rb, pb), centre when both readings match
  function automatic longint lerp(longint v, longint ra, longint rb,
                                  longint pa, longint pb, longint mid);
    if (ra == rb) return mid;
    return pa + ((v - ra) * (pb - pa)) / (rb - ra);
  endfunction

  function automatic point_t map_touch(meas_t m);
    point_t p;
    longint z, rx, ry, dx, dy;
    p = '0;
    z = longint'(m.z1) + ADC_TOP - longint'(m.z2);
    // released: pen line up (when checked) or too light a press
    if ((!pen_ignored && m.pen_up) || z < longint'(press_min)) return p;
    rx = (longint'(m.x0) + longint'(m.x1) + longint'(m.x2) + longint'(m.x3)) / 4;
    ry = (longint'(m.y0) + longint'(m.y1) + longint'(m.y2) + longint'(m.y3)) / 4;
    // axes are swapped: raw y drives screen x and raw x drives screen y
    if (cal_on) begin
      dx = lerp(ry, cal_ay, cal_by, SCR_W * CAL_PCT / 100,
                SCR_W * (100 - CAL_PCT) / 100, SCR_W / 2);
      dy = lerp(rx, cal_ax, cal_bx, SCR_H * CAL_PCT / 100,
                SCR_H * (100 - CAL_PCT) / 100, SCR_H / 2);
    end else begin
      dx = (ry - FALL_Y_LO) * SCR_W / (FALL_Y_HI - FALL_Y_LO);
      dy = (rx - FALL_X_LO) * SCR_H / (FALL_X_HI - FALL_X_LO);
    end
    p.pressed = 1'b1;
    p.sx      = 9'(clip(dx, SCR_W));
    p.sy      = 8'(clip(dy, SCR_H));
    return p;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // all four samples of an axis equal
  function automatic meas_t flat(bit pen_up, int z1, int z2, int xv, int yv);
    meas_t m;
    m = {pen_up, raw_t'(z1), raw_t'(z2), {4{raw_t'(xv)}}, {4{raw_t'(yv)}}};
    return m;
  endfunction

  function automatic point_t pt(bit p, int x, int y);
    point_t r;
    r = {p, 9'(x), 8'(y)};
    return r;
  endfunction

  function automatic void add_word(meas_t m, bit typed = 1'b0, point_t want = '0);
    row_t r;
    r.kind  = ROW_WORD;
    r.idx   = '0;
    r.data  = '0;
    r.m     = m;
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.data  = data;
    r.m     = '0;
    r.typed = 1'b0;
    r.want  = '0;
    plan.push_back(r);
  endfunction

  // centre of a sample cluster: near a calibration reading, at a rail, or anywhere
  function automatic int axis_base(raw_t a, raw_t b);
    case ($urandom_range(0, 7))
      0, 1:    return int'(a);
      2, 3:    return int'(b);
      4:       return 0;
      5:       return ADC_TOP;
      default: return int'($urandom_range(0, ADC_TOP));
    endcase
  endfunction

  // one sample near the cluster centre, now and then a wild one
  function automatic raw_t jitter(int base);
    int v;
    if ($urandom_range(0, 4) == 0) return raw_t'($urandom);
    v = base + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > ADC_TOP) v = ADC_TOP;
    return raw_t'(v);
  endfunction

  function automatic meas_t rand_word();
    meas_t m;
    int target, lo, hi, bx, by;
    m.pen_up = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 2) == 0) begin
      m.z1 = raw_t'($urandom);
      m.z2 = raw_t'($urandom);
    end else begin
      // pressure sum a few counts either side of the threshold
      target = int'(press_min) + int'($urandom_range(0, 6)) - 3;
      if (target < 0) target = 0;
      if (target > 2 * ADC_TOP) target = 2 * ADC_TOP;
      lo = (target > ADC_TOP) ? target - ADC_TOP : 0;
      hi = (target < ADC_TOP) ? target : ADC_TOP;
      m.z1 = raw_t'($urandom_range(lo, hi));
      m.z2 = raw_t'(int'(m.z1) + ADC_TOP - target);
    end
    bx = axis_base(cal_ax, cal_bx);
    by = axis_base(cal_ay, cal_by);
    m.x0 = jitter(bx);
    m.x1 = jitter(bx);
    m.x2 = jitter(bx);
    m.x3 = jitter(bx);
    m.y0 = jitter(by);
    m.y1 = jitter(by);
    m.y2 = jitter(by);
    m.y3 = jitter(by);
    return m;
  endfunction

  // offer one word and hold it until taken; valid stays up for a following word
  task automatic send_word(meas_t m, bit typed = 1'b0, point_t want = '0);
    cfg_valid <= 1'b0;
    in_valid  <= 1'b1;
    {pen_down_n, pressure_z1, pressure_z2, sample_x0, sample_x1, sample_x2, sample_x3,
     sample_y0, sample_y1, sample_y2, sample_y3} <= m;
    do @(posedge clk); while (!in_ready);
    point_q.push_back(typed ? want : map_touch(m));
    words_sent++;
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for every owed point
  task automatic quiesce();
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    // register contents are the low bits of the data
    case (idx)
      REG_CAL_VALID:          cal_on      = data[0];
      REG_CAL_A_RAW_X:        cal_ax      = data[RAW_W-1:0];
      REG_CAL_A_RAW_Y:        cal_ay      = data[RAW_W-1:0];
      REG_CAL_B_RAW_X:        cal_bx      = data[RAW_W-1:0];
      REG_CAL_B_RAW_Y:        cal_by      = data[RAW_W-1:0];
      REG_PRESSURE_THRESHOLD: press_min   = data[PRESS_W-1:0];
      REG_IGNORE_PEN_LINE:    pen_ignored = data[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- receiver

  // stalls on a pattern of its own: open stretches, coin-flip stretches, stretches ready when
  // the tick count divides by three; a bumped ticket buys one long hold-off counted here
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;
  int       hold_left = 0;
  int       hold_taken = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_taken) begin
      hold_taken <= hold_ticket;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        rx_left <= $urandom_range(5, 60);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_THIRD:  out_ready <= (rx_tick % 3 == 0);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------- point checker

  always @(posedge clk) begin : point_check
    point_t want;
    if (!rst && out_valid && out_ready) begin
      points_seen++;
      if (pressed) presses_seen++;
      if (point_q.size() == 0) begin
        $display("%0t ns: point with nothing owed: pressed %0d x %0d y %0d",
                 $time, pressed, screen_x, screen_y);
        errors++;
      end else begin
        want = point_q.pop_front();
        if (pressed !== want.pressed) begin
          $display("%0t ns: pressed expected %0d got %0d", $time, want.pressed, pressed);
          errors++;
        end
        if (screen_x !== want.sx) begin
          $display("%0t ns: screen_x expected %0d got %0d", $time, want.sx, screen_x);
          errors++;
        end
        if (screen_y !== want.sy) begin
          $display("%0t ns: screen_y expected %0d got %0d", $time, want.sy, screen_y);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    cfg_reg_t r;
    int       setv[7];
    meas_t    m;

    // reset values: fixed mapping, threshold 300, pen line checked
    add_word(flat(1, 4095, 0, 4095, 4095), 1, pt(0, 0, 0));    // pen line up
    add_word(flat(0, 0, 4095, 4095, 4095), 1, pt(0, 0, 0));    // no pressure at all
    add_word(flat(0, 0, 3796, 0, 0), 1, pt(0, 0, 0));          // one below threshold
    add_word(flat(0, 0, 3795, 0, 0), 1, pt(1, 0, 0));          // exactly on threshold
    add_word(flat(0, 4095, 0, 4095, 4095), 1, pt(1, 319, 239)); // full scale, clamped
    add_word(flat(0, 2048, 2048, 200, 300), 1, pt(1, 0, 0));    // fixed minimums
    add_word(flat(0, 2048, 2048, 3900, 3800), 1, pt(1, 319, 239)); // fixed maximums
    m = flat(0, 2048, 2048, 1, 2047);
    m.x3 = 0;  // averaging truncates 3/4 down to 0
    m.y1 = 2048;
    m.y2 = 2049;
    m.y3 = 2050;
    add_word(m);
    add_word(flat(0, 1234, 987, 2050, 2050));

    add_reg(REG_IGNORE_PEN_LINE, 1);
    add_word(flat(1, 3000, 100, 1000, 1000));                  // pen line up but ignored
    add_reg(REG_PRESSURE_THRESHOLD, 0);
    add_word(flat(1, 0, 4095, 3000, 500));                     // zero pressure still a press
    add_reg(REG_PRESSURE_THRESHOLD, 8190);
    add_word(flat(0, 4095, 0, 1500, 2500));                    // strongest press passes
    add_word(flat(0, 4094, 0, 1500, 2500), 1, pt(0, 0, 0));
    add_reg(REG_PRESSURE_THRESHOLD, 13'h1fff);
    add_word(flat(0, 4095, 0, 1500, 2500), 1, pt(0, 0, 0));    // nothing can reach it
    add_reg(REG_PRESSURE_THRESHOLD, 300);
    add_reg(REG_IGNORE_PEN_LINE, 0);

    // calibration with equal y readings: screen x sits at the centre
    add_reg(REG_CAL_A_RAW_X, 1000);
    add_reg(REG_CAL_B_RAW_X, 3000);
    add_reg(REG_CAL_A_RAW_Y, 500);
    add_reg(REG_CAL_B_RAW_Y, 500);
    add_reg(REG_CAL_VALID, 1);
    add_word(flat(0, 2048, 2048, 1000, 123), 1, pt(1, 160, 48));
    add_word(flat(0, 2048, 2048, 3000, 4095), 1, pt(1, 160, 192));
    add_word(flat(0, 2048, 2048, 0, 0));                       // off screen, clamps to 0

    // equal x readings, y points reversed so the slope is negative
    add_reg(REG_CAL_A_RAW_X, 2000);
    add_reg(REG_CAL_B_RAW_X, 2000);
    add_reg(REG_CAL_A_RAW_Y, 3500);
    add_reg(REG_CAL_B_RAW_Y, 500);
    add_word(flat(0, 2048, 2048, 55, 3500), 1, pt(1, 64, 120));
    add_word(flat(0, 2048, 2048, 4095, 0));
    add_word(flat(0, 2048, 2048, 0, 4095));                    // negative quotient

    add_reg(REG_SPARE, 13'h1fff);                              // must be ignored
    add_reg(REG_CAL_A_RAW_Y, 13'h1000);                        // top data bit dropped
    add_word(flat(0, 2048, 2048, 777, 0), 1, pt(1, 64, 120));
    add_reg(REG_CAL_VALID, 2);                                 // bit 0 clear: calibration off
    add_word(flat(0, 4095, 0, 200, 300), 1, pt(1, 0, 0));

    do @(posedge clk); while (rst);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (i == 0 || plan[i-1].kind != ROW_REG) quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].m, plan[i].typed, plan[i].want);
        pace();
      end
    end

    // random words under a series of register settings, extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // fixed mapping, no threshold, pen line ignored
        0: setv = '{0, 0, 0, 0, 0, 0, 1};
        // ordinary calibration, axes running opposite ways
        1: setv = '{1, 400, 3700, 3800, 300, 300, 0};
        // calibration points at the rails, strongest threshold
        2: setv = '{1, 0, 4095, 4095, 0, 8190, 0};
        // both axes degenerate, pen line ignored
        3: setv = '{1, 2048, 2048, 2048, 2048, 4095, 1};
        // one-count spans: steep slopes, heavy clamping
        4: setv = '{1, 2000, 1000, 2001, 999, 1, 0};
        default: foreach (setv[k]) setv[k] = $urandom_range(0, 8191);
      endcase
      quiesce();
      r = r.first();
      repeat (r.num()) begin
        write_reg(r, CFG_DATA_W'(setv[r]));
        r = r.next();
      end
      // receiver holds off while the sender floods, so the pipeline backs up
      if (ph == 1) hold_ticket++;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // sender waits out the pipeline once in the middle of each setting
        if (n == WORDS_PER_PHASE / 2) quiesce();
        send_word(rand_word());
        if (!(ph == 1 && n < FLOOD_WORDS)) pace();
      end
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (point_q.size() != 0) begin
      $display("%0t ns: %0d points never arrived", $time, point_q.size());
      errors++;
    end
    $display("tb: %0d words in, %0d points checked (%0d presses), %0d register writes",
             words_sent, points_seen, presses_seen, reg_writes);
    $display("tb: fixed and two-point mapping, centre and clamp cases, %0d random settings",
             PHASES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* touch_point_calibrated_mapping.f */
+incdir+sv
sv/tpcm_pkg.sv
sv/tpcm_front.sv
sv/tpcm_div.sv
sv/tpcm_lane.sv
sv/touch_point_calibrated_mapping.sv
bench/tb_top.sv
